// ===== hdl/sha1bc_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1bc_pkg
// Shared types and round constants of the SHA-1 block compression engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1bc_pkg;

	localparam int WORD_W      = 32;
	localparam int SCHED_DEPTH = 16;
	localparam int ROUNDS      = 80;
	localparam int CHAIN_WORDS = 5;

	localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

	// Request mode codes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DATA = 1'b1;

	// Which twenty-round group a round belongs to
	typedef enum logic [1:0] {
		PH_CHOOSE,
		PH_PARITY1,
		PH_MAJORITY,
		PH_PARITY3
	} phase_t;

	// Five working values
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] e;
	} work_t;

endpackage

// ===== hdl/sha1bc_wcell.sv =====
// ----------------------------------------------------------------------------
// sha1bc_wcell
// One cell of the message schedule chain: holds one 32-bit word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1bc_wcell (
	input  logic                             clk,
	input  logic                             shift,
	input  logic [sha1bc_pkg::WORD_W-1:0]    d,
	output logic [sha1bc_pkg::WORD_W-1:0]    q
);

	logic [sha1bc_pkg::WORD_W-1:0] word_q;

	// Take the neighbor's word on every shift, hold otherwise
	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ===== hdl/sha1bc_round.sv =====
// ----------------------------------------------------------------------------
// sha1bc_round
// One SHA-1 round: round function, constant and rotation of working values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1bc_round (
	input  sha1bc_pkg::work_t              cur,
	input  sha1bc_pkg::phase_t             phase,
	input  logic [sha1bc_pkg::WORD_W-1:0]  w,
	output sha1bc_pkg::work_t              nxt
);

	logic [sha1bc_pkg::WORD_W-1:0] f;
	logic [sha1bc_pkg::WORD_W-1:0] k;

	always_comb begin
		case (phase)
			sha1bc_pkg::PH_CHOOSE: begin
				f = (cur.b & cur.c) | (~cur.b & cur.d);
				k = sha1bc_pkg::K0;
			end
			sha1bc_pkg::PH_PARITY1: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = sha1bc_pkg::K1;
			end
			sha1bc_pkg::PH_MAJORITY: begin
				f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
				k = sha1bc_pkg::K2;
			end
			default: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = sha1bc_pkg::K3;
			end
		endcase
	end

	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + k;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

// ===== hdl/sha1_block_compress.sv =====
// ----------------------------------------------------------------------------
// sha1_block_compress
// SHA-1 compression engine with a sixteen-cell message schedule chain.
// ----------------------------------------------------------------------------
// Sequence: the sixteenth message word starts the rounds, run one per
//   cycle, then an add step that waits for a free output register.
// Throughput: one request per cycle while gathering; no request is taken
//   while the single shared round unit compresses a block of 16 words.
// Reset: arst_n clears the chaining value, word count and control state;
//   the schedule cells and working values are undefined until written.
`timescale 1ns / 1ps

module sha1_block_compress (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [2:0]                      chain_index,
	input  logic [sha1bc_pkg::WORD_W-1:0]   word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sha1bc_pkg::WORD_W-1:0]   digest_0,
	output logic [sha1bc_pkg::WORD_W-1:0]   digest_1,
	output logic [sha1bc_pkg::WORD_W-1:0]   digest_2,
	output logic [sha1bc_pkg::WORD_W-1:0]   digest_3,
	output logic [sha1bc_pkg::WORD_W-1:0]   digest_4
);

	localparam int RW = $clog2(sha1bc_pkg::ROUNDS);
	localparam int SW = $clog2(sha1bc_pkg::SCHED_DEPTH);

	typedef enum logic [1:0] {
		ST_GATHER,
		ST_ROUND,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [RW-1:0]                   round_q;
	logic [SW-1:0]                   word_count_q;
	logic [sha1bc_pkg::WORD_W-1:0]   chain_q [sha1bc_pkg::CHAIN_WORDS];
	sha1bc_pkg::work_t               work_q;
	logic                            out_valid_q;
	logic [sha1bc_pkg::WORD_W-1:0]   digest_q [sha1bc_pkg::CHAIN_WORDS];

	// Schedule chain: cell 0 holds the word of the current round
	logic [sha1bc_pkg::WORD_W-1:0]   w [sha1bc_pkg::SCHED_DEPTH];
	logic [sha1bc_pkg::WORD_W-1:0]   w_in [sha1bc_pkg::SCHED_DEPTH];
	logic [sha1bc_pkg::WORD_W-1:0]   w_expand;
	logic [sha1bc_pkg::WORD_W-1:0]   w_mix;
	logic                            shift;

	logic                            accept;
	logic                            data_accept;
	logic                            finish_go;
	sha1bc_pkg::phase_t              phase;
	sha1bc_pkg::work_t               work_nxt;
	sha1bc_pkg::work_t               start_work;
	logic [sha1bc_pkg::WORD_W-1:0]   sum [sha1bc_pkg::CHAIN_WORDS];

	assign in_ready    = (state_q == ST_GATHER);
	assign accept      = in_valid && in_ready;
	assign data_accept = accept && (mode == sha1bc_pkg::MODE_DATA);
	// Drop into the add cycle only once the output register is free
	assign finish_go   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Advance the chain on every gathered word and on every round
	assign shift = data_accept || (state_q == ST_ROUND);

	// Next schedule word W[t+16] from W[t+13], W[t+8], W[t+2] and W[t]
	assign w_mix    = w[13] ^ w[8] ^ w[2] ^ w[0];
	assign w_expand = {w_mix[30:0], w_mix[31]};

	always_comb begin
		for (int i = 0; i < sha1bc_pkg::SCHED_DEPTH - 1; i++) begin
			w_in[i] = w[i+1];
		end
		w_in[sha1bc_pkg::SCHED_DEPTH-1] = (state_q == ST_GATHER) ? word : w_expand;
	end

	for (genvar g = 0; g < sha1bc_pkg::SCHED_DEPTH; g++) begin : g_sched
		sha1bc_wcell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (w_in[g]),
			.q     (w[g])
		);
	end

	// Round group from the round index
	always_comb begin
		if (round_q < RW'(20)) begin
			phase = sha1bc_pkg::PH_CHOOSE;
		end else if (round_q < RW'(40)) begin
			phase = sha1bc_pkg::PH_PARITY1;
		end else if (round_q < RW'(60)) begin
			phase = sha1bc_pkg::PH_MAJORITY;
		end else begin
			phase = sha1bc_pkg::PH_PARITY3;
		end
	end

	sha1bc_round u_round (
		.cur   (work_q),
		.phase (phase),
		.w     (w[0]),
		.nxt   (work_nxt)
	);

	// Working values start from the chaining value as it stands at block start
	always_comb begin
		start_work.a = chain_q[0];
		start_work.b = chain_q[1];
		start_work.c = chain_q[2];
		start_work.d = chain_q[3];
		start_work.e = chain_q[4];
	end

	always_comb begin
		sum[0] = chain_q[0] + work_q.a;
		sum[1] = chain_q[1] + work_q.b;
		sum[2] = chain_q[2] + work_q.c;
		sum[3] = chain_q[3] + work_q.d;
		sum[4] = chain_q[4] + work_q.e;
	end

	// Control state and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_GATHER;
			round_q      <= '0;
			word_count_q <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < sha1bc_pkg::CHAIN_WORDS; i++) begin
				chain_q[i] <= '0;
			end
		end else begin
			// Raise on a new digest, otherwise drop once the current one is taken
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_GATHER: begin
					if (accept && (mode == sha1bc_pkg::MODE_LOAD)) begin
						// Loads past the fifth chaining word are ignored
						if (chain_index < 3'(sha1bc_pkg::CHAIN_WORDS)) begin
							chain_q[chain_index] <= word;
						end
					end
					if (data_accept) begin
						word_count_q <= word_count_q + 1'b1;
						if (word_count_q == SW'(sha1bc_pkg::SCHED_DEPTH - 1)) begin
							state_q <= ST_ROUND;
							round_q <= '0;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 1'b1;
					if (round_q == RW'(sha1bc_pkg::ROUNDS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						for (int i = 0; i < sha1bc_pkg::CHAIN_WORDS; i++) begin
							chain_q[i] <= sum[i];
						end
						state_q <= ST_GATHER;
					end
				end
				default: begin
					state_q <= ST_GATHER;
				end
			endcase
		end
	end

	// Working values and digest payload: no reset needed
	always_ff @(posedge clk) begin
		if (data_accept && (word_count_q == SW'(sha1bc_pkg::SCHED_DEPTH - 1))) begin
			work_q <= start_work;
		end else if (state_q == ST_ROUND) begin
			work_q <= work_nxt;
		end
		if (finish_go) begin
			for (int i = 0; i < sha1bc_pkg::CHAIN_WORDS; i++) begin
				digest_q[i] <= sum[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign digest_0  = digest_q[0];
	assign digest_1  = digest_q[1];
	assign digest_2  = digest_q[2];
	assign digest_3  = digest_q[3];
	assign digest_4  = digest_q[4];

	// The sixteenth word of a block starts the rounds at round zero
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(data_accept && (word_count_q == SW'(sha1bc_pkg::SCHED_DEPTH - 1)))
		|=> (state_q == ST_ROUND) && (round_q == '0))
		else $error("block did not start rounds after sixteenth word");

	// The last round hands over to the add cycle
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_ROUND) && (round_q == RW'(sha1bc_pkg::ROUNDS - 1)))
		|=> (state_q == ST_FINISH))
		else $error("rounds did not end after the last round");

	// A new result only ever comes out of the add cycle
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(finish_go))
		else $error("result raised outside the add cycle");

	// No request is taken while the rounds run
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_GATHER) |-> !in_ready)
		else $error("request ready while compressing");

endmodule
